@@ rtl/core/xtea_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

  localparam int WORD_W        = 32;
  localparam int KEY_WORDS     = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int ROUND_COUNT_D = 32;
  localparam int MIX_SHL       = 4;
  localparam int MIX_SHR       = 5;
  localparam int KEY_SHIFT     = 11;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [KEY_WORDS-1:0] key_t;

  typedef struct packed {
    word_t left;
    word_t right;
  } block_t;

  function automatic word_t mix_word(input word_t w);
    return ((w << MIX_SHL) ^ (w >> MIX_SHR)) + w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/xtea_cipher_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface xtea_cipher_if;
  logic                 valid;
  logic                 ready;
  xtea_pkg::word_t      cipher_high;
  xtea_pkg::word_t      cipher_low;

  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xtea_plain_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface xtea_plain_if;
  logic                 valid;
  logic                 ready;
  xtea_pkg::word_t      plain_high;
  xtea_pkg::word_t      plain_low;

  modport source (output valid, output plain_high, output plain_low, input ready);
  modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xtea_half_round.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xtea_half_round #(
  parameter logic [xtea_pkg::WORD_W-1:0] SUM          = '0,
  parameter bit                          UPDATE_RIGHT = 1'b1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire xtea_pkg::key_t   key,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire xtea_pkg::block_t up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output xtea_pkg::block_t      dn_data
);

  localparam logic [1:0] KEY_SEL = UPDATE_RIGHT ? 2'(SUM >> xtea_pkg::KEY_SHIFT) : SUM[1:0];

  logic             valid_r;
  xtea_pkg::block_t data_r;
  xtea_pkg::block_t data_nxt;
  xtea_pkg::word_t  src;
  xtea_pkg::word_t  tweak;

  assign src   = UPDATE_RIGHT ? up_data.left : up_data.right;
  assign tweak = xtea_pkg::mix_word(src) ^ (SUM + key[KEY_SEL]);

  always_comb begin
    data_nxt = up_data;
    if (UPDATE_RIGHT) begin
      data_nxt.right = up_data.right - tweak;
    end else begin
      data_nxt.left = up_data.left - tweak;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/core/xtea_block_decrypt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields                     Handshake
// in_blk    in   cipher_high, cipher_low    valid/ready
// out_blk   out  plain_high, plain_low      valid/ready
// cfg_*     in   cfg_index, cfg_wdata       cfg_we, no stall
//
// Each half round is one register stage.
// One transaction per cycle unless out_blk stalls; each stage's adder/xor/subtract sets fmax.
// Synchronous active-low reset clears stage valids and key words.
// Stalls compress bubbles stage by stage; the last stage is the output register.
module xtea_block_decrypt #(
  parameter int ROUND_COUNT = xtea_pkg::ROUND_COUNT_D
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [xtea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [xtea_pkg::WORD_W-1:0]     cfg_wdata,
  xtea_cipher_if.sink                          in_blk,
  xtea_plain_if.source                         out_blk
);

  localparam int STAGES = 2 * ROUND_COUNT;

  xtea_pkg::key_t   key_r;
  logic             stg_valid [STAGES+1];
  logic             stg_ready [STAGES+1];
  xtea_pkg::block_t stg_data  [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  assign stg_valid[0]      = in_blk.valid;
  assign stg_data[0].left  = in_blk.cipher_high;
  assign stg_data[0].right = in_blk.cipher_low;
  assign in_blk.ready      = stg_ready[0];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int                         RND  = g / 2;
    localparam int                         LEFT = ROUND_COUNT - RND - (g % 2);
    localparam logic [xtea_pkg::WORD_W-1:0] SUM =
      xtea_pkg::WORD_W'(64'(xtea_pkg::DELTA) * 64'(LEFT));

    xtea_half_round #(
      .SUM          (SUM),
      .UPDATE_RIGHT ((g % 2) == 0)
    ) u_half (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key_r),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_data  (stg_data[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_data  (stg_data[g+1])
    );
  end

  assign out_blk.valid      = stg_valid[STAGES];
  assign out_blk.plain_high = stg_data[STAGES].left;
  assign out_blk.plain_low  = stg_data[STAGES].right;
  assign stg_ready[STAGES]  = out_blk.ready;

endmodule

`default_nettype wire

@@ verif/xtea_plain_checker.sv @@
`timescale 1ns / 1ps

module xtea_plain_checker #(
  parameter int ROUNDS = xtea_pkg::ROUND_COUNT_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]    cfg_wdata,
  xtea_cipher_if                         cipher_mon,
  xtea_plain_if                          plain_mon,
  output int                             mismatch_count,
  output int                             pending_count
);
  import xtea_pkg::*;

  key_t   key_words;
  block_t plain_expected_q[$];
  block_t plain_exp;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic word_t feistel_mix(input word_t w);
    return ((w << MIX_SHL) ^ (w >> MIX_SHR)) + w;
  endfunction

  function automatic block_t decipher_block(input block_t ct, input key_t key);
    word_t  l;
    word_t  r;
    word_t  s;
    block_t pt;
    l = ct.left;
    r = ct.right;
    s = word_t'(DELTA * ROUNDS);
    for (int n = 0; n < ROUNDS; n++) begin
      r = r - (feistel_mix(l) ^ (s + key[s[KEY_SHIFT +: 2]]));
      s = s - DELTA;
      l = l - (feistel_mix(r) ^ (s + key[s[1:0]]));
    end
    pt.left  = l;
    pt.right = r;
    return pt;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_words <= '0;
      plain_expected_q.delete();
      pending_count <= 0;
    end else begin
      if (cipher_mon.valid && cipher_mon.ready) begin
        plain_expected_q.push_back(decipher_block({cipher_mon.cipher_high, cipher_mon.cipher_low},
                                                  key_words));
      end
      if (plain_mon.valid && plain_mon.ready) begin
        if (plain_expected_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction, expected none, actual %h %h",
                   $time, plain_mon.plain_high, plain_mon.plain_low);
        end else begin
          plain_exp = plain_expected_q.pop_front();
          if (plain_mon.plain_high !== plain_exp.left) begin
            mismatch_count++;
            $display("%0t: plain_high mismatch, expected %h, actual %h",
                     $time, plain_exp.left, plain_mon.plain_high);
          end
          if (plain_mon.plain_low !== plain_exp.right) begin
            mismatch_count++;
            $display("%0t: plain_low mismatch, expected %h, actual %h",
                     $time, plain_exp.right, plain_mon.plain_low);
          end
        end
      end
      if (cfg_we) begin
        key_words[cfg_index] <= cfg_wdata;
      end
      pending_count <= plain_expected_q.size();
    end
  end

endmodule

@@ verif/xtea_block_decrypt_tb.sv @@
`timescale 1ns / 1ps

module xtea_block_decrypt_tb;
  import xtea_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    KEY_W0_IDX,
    KEY_W1_IDX,
    KEY_W2_IDX,
    KEY_W3_IDX
  } key_idx_t;

  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 5000;
  localparam int PHASE_ITEMS    = 150;
  localparam int RANDOM_PHASES  = 7;
  localparam int DRAIN_CYCLES   = 2 * ROUND_COUNT_D + 16;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_wdata;
  logic                 idle_on;
  logic                 hold_req;
  int                   mismatch_count;
  int                   pending_count;
  int                   quiet_cycles;

  xtea_cipher_if cipher_ch();
  xtea_plain_if  plain_ch();

  xtea_block_decrypt dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_blk    (cipher_ch),
    .out_blk   (plain_ch)
  );

  xtea_plain_checker #(.ROUNDS(ROUND_COUNT_D)) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cipher_mon     (cipher_ch),
    .plain_mon      (plain_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((cipher_ch.valid && cipher_ch.ready) || (plain_ch.valid && plain_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    plain_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        plain_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      plain_ch.ready <= !(idle_on && ($urandom_range(99) < 34));
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(WORD_W - 1);
      3:       return ~(word_t'(1) << $urandom_range(WORD_W - 1));
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(input key_idx_t idx, input word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
    write_reg(KEY_W0_IDX, k0);
    write_reg(KEY_W1_IDX, k1);
    write_reg(KEY_W2_IDX, k2);
    write_reg(KEY_W3_IDX, k3);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_block(input word_t hi, input word_t lo);
    while (idle_on && ($urandom_range(99) < 34)) begin
      cipher_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cipher_ch.valid       <= 1'b1;
    cipher_ch.cipher_high <= hi;
    cipher_ch.cipher_low  <= lo;
    @(posedge clk);
    while (!cipher_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    cipher_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  task automatic send_corners();
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = KEY_W0_IDX;
    cfg_wdata             = '0;
    cipher_ch.valid       = 1'b0;
    cipher_ch.cipher_high = '0;
    cipher_ch.cipher_low  = '0;
    idle_on               = 1'b1;
    hold_req              = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset key is all zero
    send_corners();
    drain();
    load_key('1, '1, '1, '1);
    send_corners();
    drain();
    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
    send_block(32'h4142_4344, 32'h4546_4748);
    send_block(32'h4972_0E15, 32'hFE1C_03A7);
    send_block(32'h0123_4567, 32'h89AB_CDEF);
    send_block(32'hDEAD_BEEF, 32'h0BAD_F00D);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       load_key('0, '0, '0, '0);
        1:       load_key('1, '1, '1, '1);
        default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
      endcase
      idle_on = (ph != 2);
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_block(rand_word(), rand_word());
      end
      drain();
    end
    idle_on = 1'b1;

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
